// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL top level.
// Each macro expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition now implies a result in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// ===== hdl/rsqc_pkg.sv =====
// Shared types, constants and helpers for the rotated sprite quad corner core.
// No dependencies.
`default_nettype none
package rsqc_pkg;

  localparam int RSQC_ANGLE_BITS = 16;
  localparam int RSQC_SINE_DEPTH = 1024;

  // sine unit registers, and full pipeline depth including output
  localparam int TRIG_STAGES = 7;
  localparam int PIPE_STAGES = 11;

  // quarter-wave polynomial coefficients, unsigned Q1.14
  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [14:0] SIN_B   = 15'd10544;
  localparam logic [10:0] SIN_C   = 11'd1192;
  localparam logic [14:0] QUARTER = 15'd16384;

  typedef enum logic [2:0] {
    REG_TILE  = 3'd0,
    REG_WIN_W = 3'd1,
    REG_WIN_H = 3'd2,
    REG_CAM_X = 3'd3,
    REG_CAM_Y = 3'd4,
    REG_CAM_Z = 3'd5
  } reg_idx_t;

  localparam logic [15:0]        TILE_RST  = 16'd1024;
  localparam logic [13:0]        WIN_W_RST = 14'd1280;
  localparam logic [13:0]        WIN_H_RST = 14'd720;
  localparam logic signed [31:0] CAM_RST   = 32'sd655360;

  typedef struct packed {
    logic               screen;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        sx;
    logic [15:0]        sy;
    logic [15:0]        tex;
    logic [31:0]        color;
    logic               last;
  } sprite_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rsqc_trig.sv =====
// Pipelined sine/cosine unit: angle to table phase, then quarter-wave polynomial.
// Depends on rsqc_pkg. Seven register stages, each loaded by its own enable.
`default_nettype none
module rsqc_trig #(
  parameter int ANGLE_BITS       = rsqc_pkg::RSQC_ANGLE_BITS,
  parameter int SINE_TABLE_DEPTH = rsqc_pkg::RSQC_SINE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic [rsqc_pkg::TRIG_STAGES-1:0] stage_en,
  input  wire logic [15:0]                      angle,
  output logic signed [15:0]                    sin_o,
  output logic signed [15:0]                    cos_o
);
  import rsqc_pkg::*;

  localparam int IDXW = $clog2(SINE_TABLE_DEPTH);
  localparam int K    = 2 * IDXW;
  localparam int RHW  = IDXW + 2;
  localparam int SW   = IDXW + RHW + 17;
  localparam int AW   = ANGLE_BITS + IDXW + 1;
  // reciprocal of the depth, exact for every index below the depth
  localparam logic [63:0] RECIP =
    ((64'd1 << (16 + K)) + 64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH);
  localparam logic [15:0]    RECIP_LO = RECIP[15:0];
  localparam logic [RHW-1:0] RECIP_HI = RECIP[RHW+15:16];
  localparam logic [IDXW:0]  DEPTH_W  = (IDXW + 1)'(SINE_TABLE_DEPTH);

  logic [IDXW-1:0]      idx_r, idx_nxt;
  logic [IDXW+15:0]     plo_r;
  logic [IDXW+RHW-1:0]  phi_r;
  logic [15:0]          ph_r;
  logic [15:0]          ph_cos;
  logic [AW-1:0]        ang_scaled;
  logic [SW-1:0]        ph_sum;

  // lane 0 sine, lane 1 cosine
  logic [14:0] x4_r [2];
  logic [14:0] x2_4_r [2];
  logic        neg4_r [2];
  logic [14:0] x5_r [2];
  logic [14:0] x2_5_r [2];
  logic [14:0] t5_r [2];
  logic        neg5_r [2];
  logic [14:0] x6_r [2];
  logic [14:0] u6_r [2];
  logic        neg6_r [2];
  logic signed [15:0] s7_r [2];

  logic [14:0] x_nxt [2];
  logic [14:0] x2_nxt [2];
  logic [14:0] t_nxt [2];
  logic [14:0] u_nxt [2];
  logic signed [15:0] s_nxt [2];

  assign ang_scaled = AW'(angle[15:16-ANGLE_BITS]) * AW'(DEPTH_W);
  assign idx_nxt    = ang_scaled[ANGLE_BITS+IDXW-1:ANGLE_BITS];
  assign ph_sum     = (SW'(phi_r) << 16) + SW'(plo_r);
  assign ph_cos     = ph_r + 16'(QUARTER);

  always_comb begin
    logic [15:0] p;
    logic [29:0] sq;
    logic [25:0] mc;
    logic [29:0] mt;
    logic [29:0] mu;
    logic [14:0] s;
    for (int l = 0; l < 2; l++) begin
      p = (l == 0) ? ph_r : ph_cos;
      x_nxt[l]  = p[14] ? (QUARTER - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
      sq        = 30'(x_nxt[l]) * 30'(x_nxt[l]);
      x2_nxt[l] = sq[28:14];
      mc        = 26'(x2_4_r[l]) * 26'(SIN_C);
      t_nxt[l]  = SIN_B - {3'b0, mc[25:14]};
      mt        = 30'(x2_5_r[l]) * 30'(t5_r[l]);
      u_nxt[l]  = SIN_A - mt[28:14];
      mu        = 30'(x6_r[l]) * 30'(u6_r[l]);
      s         = (mu[29:14] > 16'(QUARTER)) ? QUARTER : mu[28:14];
      s_nxt[l]  = neg6_r[l] ? -signed'({1'b0, s}) : signed'({1'b0, s});
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      idx_r <= idx_nxt;
    end
    if (stage_en[1]) begin
      plo_r <= (IDXW + 16)'(idx_r) * (IDXW + 16)'(RECIP_LO);
      phi_r <= (IDXW + RHW)'(idx_r) * (IDXW + RHW)'(RECIP_HI);
    end
    if (stage_en[2]) begin
      ph_r <= ph_sum[K+15:K];
    end
    for (int l = 0; l < 2; l++) begin
      if (stage_en[3]) begin
        x4_r[l]   <= x_nxt[l];
        x2_4_r[l] <= x2_nxt[l];
        neg4_r[l] <= (l == 0) ? ph_r[15] : ph_cos[15];
      end
      if (stage_en[4]) begin
        x5_r[l]   <= x4_r[l];
        x2_5_r[l] <= x2_4_r[l];
        t5_r[l]   <= t_nxt[l];
        neg5_r[l] <= neg4_r[l];
      end
      if (stage_en[5]) begin
        x6_r[l]   <= x5_r[l];
        u6_r[l]   <= u_nxt[l];
        neg6_r[l] <= neg5_r[l];
      end
      if (stage_en[6]) begin
        s7_r[l] <= s_nxt[l];
      end
    end
  end

  assign sin_o = s7_r[0];
  assign cos_o = s7_r[1];

endmodule
`default_nettype wire

// ===== hdl/rotated_sprite_quad_corners_core.sv =====
// Rotated sprite quad corner transform, top level.
// Depends on rsqc_pkg, rsqc_trig and assert_macros.svh.
//
// Usage:
//   Input channel (in_*): one sprite word per accepted handshake
//   (in_valid high, in_stall low at a rising edge).
//   Output channel (out_*): one quad word per sprite, same order.
//   Path: a word accepted into the first of 11 register stages leaves
//   from the last under out_valid; a stalled output word holds steady.
//   Throughput: one sprite per cycle while in_stall is low. Every
//   stage holds a valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles collapse and in_stall rises
//   only once all 11 stages hold a word and out_stall is high.
//   Stages: 7 in the sine unit (phase, polynomial), then half axes,
//   corner sums, tile-scale partial products, final add and saturate.
//   Configuration: APB write and read port, pready tied high; registers at
//   byte addresses 4*i. Write only while the pipeline is empty.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register reset values.
`default_nettype none
`include "assert_macros.svh"
module rotated_sprite_quad_corners_core #(
  parameter int ANGLE_BITS       = rsqc_pkg::RSQC_ANGLE_BITS,
  parameter int SINE_TABLE_DEPTH = rsqc_pkg::RSQC_SINE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // sprite input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_screen_space,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [15:0] in_size_x,
  input  wire logic [15:0] in_size_y,
  input  wire logic [15:0] in_angle,
  input  wire logic [15:0] in_texture_id,
  input  wire logic [31:0] in_color_rgba,
  input  wire logic        in_last_item,
  // quad output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_ll_x,
  output logic [31:0]      out_ll_y,
  output logic [31:0]      out_lr_x,
  output logic [31:0]      out_lr_y,
  output logic [31:0]      out_ur_x,
  output logic [31:0]      out_ur_y,
  output logic [31:0]      out_ul_x,
  output logic [31:0]      out_ul_y,
  output logic [31:0]      out_depth,
  output logic [15:0]      out_texture_out,
  output logic [31:0]      out_color_out,
  output logic             out_last_out
);
  import rsqc_pkg::*;

  localparam int TS = TRIG_STAGES;

  // ---------------- configuration registers ----------------
  logic [15:0]        tile_r;
  logic [13:0]        win_w_r, win_h_r;
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r  <= TILE_RST;
      win_w_r <= WIN_W_RST;
      win_h_r <= WIN_H_RST;
      cam_x_r <= CAM_RST;
      cam_y_r <= CAM_RST;
      cam_z_r <= CAM_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_TILE:  tile_r  <= pwdata[15:0];
        REG_WIN_W: win_w_r <= pwdata[13:0];
        REG_WIN_H: win_h_r <= pwdata[13:0];
        REG_CAM_X: cam_x_r <= pwdata;
        REG_CAM_Y: cam_y_r <= pwdata;
        REG_CAM_Z: cam_z_r <= pwdata;
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_TILE:  prdata = {16'b0, tile_r};
      REG_WIN_W: prdata = {18'b0, win_w_r};
      REG_WIN_H: prdata = {18'b0, win_h_r};
      REG_CAM_X: prdata = cam_x_r;
      REG_CAM_Y: prdata = cam_y_r;
      REG_CAM_Z: prdata = cam_z_r;
      default:   prdata = 32'b0;
    endcase
  end

  // ---------------- stage valid bits and advance chain ----------------
  logic [PIPE_STAGES-1:0] v_r, adv;

  always_comb begin
    adv[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[PIPE_STAGES-1];

  // ---------------- stages 0..6: sine unit, sprite word rides alongside ----------------
  sprite_t            in_spr;
  sprite_t            spr_r [TS];
  logic signed [15:0] sin_w, cos_w;

  always_comb begin
    in_spr.screen = in_screen_space;
    in_spr.px     = in_pos_x;
    in_spr.py     = in_pos_y;
    in_spr.pz     = in_pos_z;
    in_spr.sx     = in_size_x;
    in_spr.sy     = in_size_y;
    in_spr.tex    = in_texture_id;
    in_spr.color  = in_color_rgba;
    in_spr.last   = in_last_item;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      spr_r[0] <= in_spr;
    end
    for (int k = 1; k < TS; k++) begin
      if (adv[k]) begin
        spr_r[k] <= spr_r[k-1];
      end
    end
  end

  rsqc_trig #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_trig (
    .clk     (clk),
    .stage_en(adv[TS-1:0]),
    .angle   (in_angle),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  // ---------------- stage 7: half axes, centre, depth ----------------
  sprite_t            s6;
  logic signed [16:0] sx_s, sy_s, nsn;
  logic signed [32:0] p_xax, p_xay, p_yax, p_yay;
  logic signed [34:0] ox_nxt, oy_nxt;
  logic signed [63:0] dz;

  logic signed [25:0] xax_r, xay_r, yax_r, yay_r;
  logic signed [34:0] ox_r, oy_r;
  logic [31:0]        depth7_r;
  logic               scr7_r, last7_r;
  logic [15:0]        tex7_r;
  logic [31:0]        col7_r;

  assign s6   = spr_r[TS-1];
  assign sx_s = signed'({1'b0, s6.sx});
  assign sy_s = signed'({1'b0, s6.sy});
  assign nsn  = -17'(sin_w);

  assign p_xax = cos_w * sx_s;
  assign p_xay = sin_w * sx_s;
  assign p_yax = nsn * sy_s;
  assign p_yay = cos_w * sy_s;

  // centre = lower left + half size, camera relative in world mode
  assign ox_nxt = 35'(s6.px) + 35'(signed'({1'b0, s6.sx, 7'b0}))
                - (s6.screen ? 35'sd0 : 35'(cam_x_r));
  assign oy_nxt = 35'(s6.py) + 35'(signed'({1'b0, s6.sy, 7'b0}))
                - (s6.screen ? 35'sd0 : 35'(cam_y_r));
  assign dz     = 64'(s6.pz) - (s6.screen ? 64'sd0 : 64'(cam_z_r));

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      xax_r    <= p_xax[32:7];   // floor shift
      xay_r    <= p_xay[32:7];
      yax_r    <= p_yax[32:7];
      yay_r    <= p_yay[32:7];
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      depth7_r <= sat32(dz);
      scr7_r   <= s6.screen;
      tex7_r   <= s6.tex;
      col7_r   <= s6.color;
      last7_r  <= s6.last;
    end
  end

  // ---------------- stage 8: corner sums ----------------
  // coordinate j: corner j/2 (ll, lr, ur, ul), x when j even
  logic signed [35:0] c_nxt [8];
  logic signed [35:0] c8_r [8];
  logic [31:0]        depth8_r;
  logic               scr8_r, last8_r;
  logic [15:0]        tex8_r;
  logic [31:0]        col8_r;

  always_comb begin
    logic signed [35:0] o, a1, a2;
    logic               pos1, pos2;
    for (int j = 0; j < 8; j++) begin
      pos1 = ((j >> 1) == 1) || ((j >> 1) == 2);
      pos2 = (j >> 1) >= 2;
      o    = (j % 2 == 0) ? 36'(ox_r) : 36'(oy_r);
      a1   = (j % 2 == 0) ? 36'(xax_r) : 36'(xay_r);
      a2   = (j % 2 == 0) ? 36'(yax_r) : 36'(yay_r);
      c_nxt[j] = o + (pos1 ? a1 : -a1) + (pos2 ? a2 : -a2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      c8_r     <= c_nxt;
      depth8_r <= depth7_r;
      scr8_r   <= scr7_r;
      tex8_r   <= tex7_r;
      col8_r   <= col7_r;
      last8_r  <= last7_r;
    end
  end

  // ---------------- stage 9: tile scale partial products ----------------
  logic signed [16:0] tile_s;
  logic [33:0]        plo_nxt [8];
  logic signed [34:0] phi_nxt [8];
  logic [31:0]        scr_nxt [8];
  logic [33:0]        plo9_r [8];
  logic signed [34:0] phi9_r [8];
  logic [31:0]        scrv9_r [8];
  logic [31:0]        depth9_r;
  logic               scr9_r, last9_r;
  logic [15:0]        tex9_r;
  logic [31:0]        col9_r;

  assign tile_s = signed'({1'b0, tile_r});

  always_comb begin
    logic signed [17:0] hi;
    logic signed [63:0] ce, cs;
    for (int j = 0; j < 8; j++) begin
      hi         = c8_r[j][35:18];
      plo_nxt[j] = 34'(c8_r[j][17:0]) * 34'(tile_r);
      phi_nxt[j] = hi * tile_s;
      ce         = 64'(c8_r[j]);
      cs         = ce >>> 8;
      scr_nxt[j] = sat32(cs);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      plo9_r   <= plo_nxt;
      phi9_r   <= phi_nxt;
      scrv9_r  <= scr_nxt;
      depth9_r <= depth8_r;
      scr9_r   <= scr8_r;
      tex9_r   <= tex8_r;
      col9_r   <= col8_r;
      last9_r  <= last8_r;
    end
  end

  // ---------------- stage 10: final sum, window offset, saturate ----------------
  logic [31:0] res_nxt [8];
  logic [31:0] res_r [8];
  logic [31:0] depth_r, col_r;
  logic [15:0] tex_r;
  logic        last_r;

  always_comb begin
    logic signed [63:0] full, sh, win, v;
    for (int j = 0; j < 8; j++) begin
      full = (64'(phi9_r[j]) <<< 18) + signed'(64'(plo9_r[j]));
      sh   = full >>> 12;
      win  = (j % 2 == 0) ? signed'(64'({win_w_r, 7'b0})) : signed'(64'({win_h_r, 7'b0}));
      v    = sh + win;
      res_nxt[j] = scr9_r ? scrv9_r[j] : sat32(v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      res_r   <= res_nxt;
      depth_r <= depth9_r;
      tex_r   <= tex9_r;
      col_r   <= col9_r;
      last_r  <= last9_r;
    end
  end

  assign out_ll_x        = res_r[0];
  assign out_ll_y        = res_r[1];
  assign out_lr_x        = res_r[2];
  assign out_lr_y        = res_r[3];
  assign out_ur_x        = res_r[4];
  assign out_ur_y        = res_r[5];
  assign out_ul_x        = res_r[6];
  assign out_ul_y        = res_r[7];
  assign out_depth       = depth_r;
  assign out_texture_out = tex_r;
  assign out_color_out   = col_r;
  assign out_last_out    = last_r;

  // ---------------- assertions ----------------
  logic acc_in, acc_out;
  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;

  `ASSERT_CLK(a_stall_only_when_full, !in_stall || ((&v_r) && out_stall), "in_stall with room in pipe")
  `ASSERT_NEXT(a_occupancy_up, acc_in && !acc_out, $countones(v_r) == $past($countones(v_r)) + 1, "word lost in pipe")
  `ASSERT_NEXT(a_cfg_tile, cfg_wr && (paddr[4:2] == REG_TILE), tile_r == $past(pwdata[15:0]), "tile size write missed")

endmodule
`default_nettype wire
